// ===== rtl/core/fba_pkg.sv =====
`default_nettype none
package fba_pkg;

    localparam int CFG_W          = 17;
    localparam int OP_W           = 2;
    localparam int FRAME_W        = 36;
    localparam int FREE_W         = 16;
    localparam int WORD_W         = 32;
    localparam int BIT_W          = 5;
    localparam int HINT_W         = 17;
    localparam int WIDX_W         = CFG_W - BIT_W;
    localparam int MAX_FRAMES_DEF = 65536;

    localparam logic [OP_W-1:0] OP_MARK_USED = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND      = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [FRAME_W-1:0] frame_number;
    } t_req;

    typedef struct packed {
        logic              found;
        logic [FREE_W-1:0] free_frame;
    } t_rsp;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              has_zero;
        logic [BIT_W-1:0]  zero_pos;
    } t_unit_res;

endpackage
`default_nettype wire

// ===== rtl/core/frame_bitmap_allocator.sv =====
// an in-range mark used or mark free goes through S_RD, S_MOD and S_DONE before its response is registered
// find tests one word per pass through S_RD and S_MOD, from the hint word up to the last whole word, then S_DONE
// other requests, and find with the hint at or past the last whole word, go straight to S_DONE
// throughput: one request at a time; the single bitmap read port and word unit set the scan rate
// reset: after i_rst_n the bitmap is filled with ones, one word per cycle, over all (MAX_FRAMES + 31) / 32
// words, with o_req_ready low; hint and frame count reset to zero
`default_nettype none
module frame_bitmap_allocator import fba_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    output logic                  o_req_ready,
    input  wire t_req             i_req,
    output logic                  o_rsp_valid,
    input  wire logic             i_rsp_ready,
    output t_rsp                  o_rsp,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int WORD_COUNT = (MAX_FRAMES + 31) / 32;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_MOD, S_DONE} t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [WIDX_W-1:0]   r_idx, n_idx;
    logic [WIDX_W-1:0]   r_last, n_last;
    logic [OP_W-1:0]     r_op, n_op;
    logic [CFG_W-1:0]    r_frame, n_frame;
    logic [HINT_W-1:0]   r_hint, n_hint;
    logic [CFG_W-1:0]    r_frame_count, n_frame_count;
    logic                r_res_found, n_res_found;
    logic [FREE_W-1:0]   r_res_frame, n_res_frame;
    logic                r_out_valid, n_out_valid;
    t_rsp                r_out, n_out;

    logic [CFG_W-1:0]    eff_count;
    logic [WIDX_W-1:0]   last_word;
    logic [WIDX_W-1:0]   hint_word;
    logic [WIDX_W-1:0]   idx_inc;
    logic [HINT_W-1:0]   found_frame;
    logic                in_range;
    logic                is_mark;

    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;
    t_unit_res           unit_res;

    assign eff_count = (32'(r_frame_count) > 32'(MAX_FRAMES)) ? CFG_W'(MAX_FRAMES)
                                                              : r_frame_count;
    assign last_word   = eff_count[CFG_W-1:BIT_W];
    assign hint_word   = r_hint[HINT_W-1:BIT_W];
    assign in_range    = (i_req.frame_number < FRAME_W'(eff_count));
    assign is_mark     = (i_req.operation == OP_MARK_USED) || (i_req.operation == OP_MARK_FREE);
    assign idx_inc     = r_idx + WIDX_W'(1);
    assign found_frame = {r_idx, unit_res.zero_pos};

    assign ram_we    = (r_state == S_CLEAR) || ((r_state == S_MOD) && (r_op != OP_FIND));
    assign ram_addr  = (r_state == S_CLEAR) ? r_clr : AW'(r_idx);
    assign ram_wdata = (r_state == S_CLEAR) ? '1 : unit_res.word;

    fba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    fba_word_unit u_unit (
        .i_word  (ram_rdata),
        .i_bit   (r_frame[BIT_W-1:0]),
        .i_clear (r_op == OP_MARK_FREE),
        .o_res   (unit_res)
    );

    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_idx         = r_idx;
        n_last        = r_last;
        n_op          = r_op;
        n_frame       = r_frame;
        n_hint        = r_hint;
        n_frame_count = r_frame_count;
        n_res_found   = r_res_found;
        n_res_frame   = r_res_frame;
        n_out_valid   = r_out_valid;
        n_out         = r_out;

        if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_valid) begin
            n_frame_count = i_cfg_data;
        end

        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(WORD_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op        = i_req.operation;
                    n_frame     = i_req.frame_number[CFG_W-1:0];
                    n_res_found = 1'b0;
                    n_res_frame = '0;
                    priority if (is_mark && in_range) begin
                        n_idx   = i_req.frame_number[CFG_W-1:BIT_W];
                        n_state = S_RD;
                    end else if ((i_req.operation == OP_FIND) && (hint_word < last_word)) begin
                        n_idx   = hint_word;
                        n_last  = last_word;
                        n_state = S_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RD: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (r_op == OP_FIND) begin
                    priority if (unit_res.has_zero) begin
                        n_res_found = 1'b1;
                        n_res_frame = found_frame[FREE_W-1:0];
                        n_hint      = found_frame + HINT_W'(1);
                        n_state     = S_DONE;
                    end else if (idx_inc < r_last) begin
                        n_idx   = idx_inc;
                        n_state = S_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    // frame is below the count here, so 17 bits hold it
                    if ((r_op == OP_MARK_FREE) && (r_frame < r_hint)) begin
                        n_hint = r_frame;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.found      = r_res_found;
                    n_out.free_frame = r_res_frame;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_hint        <= '0;
            r_frame_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr         <= n_clr;
            r_hint        <= n_hint;
            r_frame_count <= n_frame_count;
            r_out_valid   <= n_out_valid;
        end
        r_idx       <= n_idx;
        r_last      <= n_last;
        r_op        <= n_op;
        r_frame     <= n_frame;
        r_res_found <= n_res_found;
        r_res_frame <= n_res_frame;
        r_out       <= n_out;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    a_ram_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_CLEAR) || (r_state == S_MOD)))
        else $error("bitmap written outside clear or modify");

    a_scan_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) && (r_op == OP_FIND)) |-> (r_idx < r_last))
        else $error("scan word beyond the last full word");

    a_mark_no_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MOD) && (r_op != OP_FIND)) |=> ((r_state == S_DONE) && !r_res_found))
        else $error("mark transaction reported a found frame");

    a_zero_when_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.found) |-> (o_rsp.free_frame == '0))
        else $error("free_frame nonzero without found");

endmodule
`default_nettype wire

// ===== rtl/core/fba_ram.sv =====
`default_nettype none
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/core/fba_word_unit.sv =====
`default_nettype none
module fba_word_unit import fba_pkg::*; (
    input  wire logic [WORD_W-1:0] i_word,
    input  wire logic [BIT_W-1:0]  i_bit,
    input  wire logic              i_clear,
    output t_unit_res              o_res
);

    logic [WORD_W-1:0] bit_mask;
    logic [WORD_W-1:0] low_zero;
    logic [BIT_W-1:0]  pos;

    assign bit_mask = WORD_W'(1) << i_bit;
    // one-hot of the lowest clear bit
    assign low_zero = ~i_word & (i_word + WORD_W'(1));

    always_comb begin
        pos = '0;
        for (int k = 0; k < WORD_W; k++) begin
            if (low_zero[k]) begin
                pos = pos | BIT_W'(k);
            end
        end
    end

    always_comb begin
        o_res.word     = i_clear ? (i_word & ~bit_mask) : (i_word | bit_mask);
        o_res.has_zero = (i_word != '1);
        o_res.zero_pos = pos;
    end

endmodule
`default_nettype wire

// ===== verif/frame_bitmap_allocator_test.sv =====
module frame_bitmap_allocator_test;
    import fba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORDS = (MAX_FRAMES_DEF + 31) / 32;
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
    localparam logic [FRAME_W-1:0] FRAME_ALL_ONES = {FRAME_W{1'b1}};

    // shadow of the allocator: bitmap, hint, frame count and pending responses
    class bitmap_tracker;
        logic [WORD_W-1:0] used_words [WORDS];
        logic [HINT_W-1:0] hint;
        logic [CFG_W-1:0]  frame_count;
        t_rsp              expected_rsp [$];
        int                mismatches;

        function new();
            foreach (used_words[i]) used_words[i] = '1;
            hint = '0;
            frame_count = '0;
            mismatches = 0;
        endfunction

        function int unsigned effective_count();
            if (frame_count > MAX_FRAMES_DEF) begin
                return 32'(MAX_FRAMES_DEF);
            end
            return 32'(frame_count);
        endfunction

        function int lowest_free();
            int unsigned count;
            count = effective_count();
            for (int unsigned f = 0; f < count; f++) begin
                if (!used_words[f >> BIT_W][f[BIT_W-1:0]]) begin
                    return int'(f);
                end
            end
            return -1;
        endfunction

        function void note_request(t_req r);
            int unsigned count;
            int unsigned last;
            int unsigned idx;
            logic [BIT_W-1:0] pos;
            logic [HINT_W-1:0] frame;
            bit hit;
            t_rsp rsp;
            count = effective_count();
            rsp = '0;
            case (r.operation)
                OP_MARK_USED, OP_MARK_FREE: begin
                    if (r.frame_number < count) begin
                        idx = int'(r.frame_number >> BIT_W);
                        pos = r.frame_number[BIT_W-1:0];
                        if (r.operation == OP_MARK_USED) begin
                            used_words[idx][pos] = 1'b1;
                        end else begin
                            used_words[idx][pos] = 1'b0;
                            if (r.frame_number < hint) begin
                                hint = r.frame_number[HINT_W-1:0];
                            end
                        end
                    end
                end
                OP_FIND: begin
                    last = count >> BIT_W;
                    hit = 1'b0;
                    // whole words only, partial last word excluded
                    for (idx = 32'(hint >> BIT_W); idx < last && !hit; idx++) begin
                        for (int j = 0; j < WORD_W; j++) begin
                            if (!hit && !used_words[idx][j]) begin
                                hit = 1'b1;
                                frame = HINT_W'((idx << BIT_W) + j);
                                rsp.found = 1'b1;
                                rsp.free_frame = frame[FREE_W-1:0];
                                hint = frame + 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            expected_rsp.push_back(rsp);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (expected_rsp.size() == 0) begin
                $display("%0t: extra response, expected none, actual %0d/%0d",
                         $time, got.found, got.free_frame);
                mismatches++;
                return;
            end
            want = expected_rsp.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: found mismatch, expected %0d, actual %0d",
                         $time, want.found, got.found);
                mismatches++;
            end
            if (got.free_frame !== want.free_frame) begin
                $display("%0t: free_frame mismatch, expected %0d, actual %0d",
                         $time, want.free_frame, got.free_frame);
                mismatches++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_req_valid = 1'b0;
    logic             o_req_ready;
    t_req             i_req = '0;
    logic             o_rsp_valid;
    logic             i_rsp_ready = 1'b0;
    t_rsp             o_rsp;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;

    bitmap_tracker tracker = new();
    int burst_left = 1;
    bit paused_once = 1'b0;

    int first_counts [10] = '{1, 31, 32, 64, 100, 0, 255, 1000, 2048, 96};
    int first_items  [10] = '{12, 30, 30, 40, 45, 8, 45, 45, 45, 40};

    frame_bitmap_allocator #(
        .MAX_FRAMES(MAX_FRAMES_DEF)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic issue(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] frame);
        t_req r;
        r.operation = op;
        r.frame_number = frame;
        i_req <= r;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        tracker.note_request(r);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
                i_req_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_req_valid <= 1'b0;
        while (tracker.expected_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_frame_count(input logic [CFG_W-1:0] value);
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.frame_count = value;
    endtask

    function automatic logic [FRAME_W-1:0] pick_frame(input bit spread);
        int unsigned count;
        int unsigned roll;
        logic [31:0] hi;
        count = tracker.effective_count();
        roll = $urandom_range(0, 99);
        hi = $urandom();
        if (count > 0 && roll < (spread ? 90 : 80)) begin
            return FRAME_W'($urandom_range(0, count - 1));
        end else if (roll < 90) begin
            return FRAME_W'(count + $urandom_range(0, 3));
        end
        return {hi[3:0], $urandom()};
    endfunction

    task automatic random_items(input int n, input bit spread);
        int unsigned roll;
        logic [OP_W-1:0] op;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (spread) begin
                op = roll < 50 ? OP_MARK_FREE : roll < 70 ? OP_MARK_USED :
                     roll < 95 ? OP_FIND : OP_UNKNOWN;
            end else begin
                op = roll < 35 ? OP_MARK_FREE : roll < 60 ? OP_MARK_USED :
                     roll < 93 ? OP_FIND : OP_UNKNOWN;
            end
            issue(op, pick_frame(spread));
            // one mid-phase pause until the pipeline is empty
            if (!paused_once && n > 30 && k == n / 2) begin
                paused_once = 1'b1;
                drain();
            end
        end
    endtask

    // response side: stall pattern, one long hold-off to back up the request side
    initial begin
        int seen;
        int hold_left;
        int mode;
        int tick;
        bit held;
        seen = 0;
        hold_left = 0;
        mode = 0;
        tick = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
                tracker.check_response(o_rsp);
                seen++;
            end
            if (seen == 150 && !held) begin
                held = 1'b1;
                hold_left = 400;
            end
            tick++;
            if (tick % 64 == 0) mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                i_rsp_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_rsp_ready <= 1'b1;
                    1: i_rsp_ready <= 1'($urandom_range(0, 1));
                    2: i_rsp_ready <= (tick % 5 == 0);
                    default: i_rsp_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int f;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // frame count still zero: everything out of range
        issue(OP_FIND, '0);
        issue(OP_MARK_FREE, '0);
        issue(OP_MARK_USED, '0);
        issue(OP_UNKNOWN, FRAME_ALL_ONES);
        drain();

        write_frame_count(CFG_W'(33));
        issue(OP_MARK_FREE, FRAME_W'(32));   // partial last word, never found
        issue(OP_FIND, '0);
        issue(OP_MARK_FREE, FRAME_W'(0));
        issue(OP_FIND, FRAME_ALL_ONES);
        issue(OP_FIND, '0);                  // frame not taken by find
        issue(OP_MARK_USED, FRAME_W'(0));
        issue(OP_FIND, '0);
        issue(OP_MARK_FREE, FRAME_W'(31));
        issue(OP_FIND, '0);
        issue(OP_FIND, '0);                  // hint past the last whole word
        issue(OP_MARK_FREE, FRAME_W'(33));
        issue(OP_MARK_FREE, FRAME_ALL_ONES);
        issue(OP_MARK_USED, FRAME_ALL_ONES);
        issue(OP_MARK_USED, {1'b1, {(FRAME_W-1){1'b0}}} | FRAME_W'(1));
        issue(OP_MARK_FREE, FRAME_W'(5));    // lowers the hint
        issue(OP_FIND, '0);
        issue(OP_UNKNOWN, '0);
        drain();

        for (int p = 0; p < 10; p++) begin
            write_frame_count(CFG_W'(first_counts[p]));
            random_items(first_items[p], 1'b0);
            drain();
        end

        // full capacity: mark every free frame used, then walk the top of the map
        write_frame_count(CFG_W'(MAX_FRAMES_DEF));
        f = tracker.lowest_free();
        while (f >= 0) begin
            issue(OP_MARK_USED, FRAME_W'(f));
            f = tracker.lowest_free();
        end
        issue(OP_MARK_FREE, FRAME_W'(0));
        issue(OP_MARK_USED, FRAME_W'(0));
        issue(OP_FIND, '0);                  // nothing free, full scan
        issue(OP_MARK_FREE, FRAME_W'(MAX_FRAMES_DEF - 1));
        issue(OP_FIND, '0);
        issue(OP_FIND, '0);
        issue(OP_MARK_FREE, FRAME_W'(40000));
        issue(OP_FIND, '0);
        issue(OP_MARK_FREE, FRAME_W'(MAX_FRAMES_DEF));
        random_items(8, 1'b1);
        drain();

        write_frame_count({CFG_W{1'b1}});    // clipped to capacity
        random_items(8, 1'b1);
        drain();

        write_frame_count(CFG_W'(MAX_FRAMES_DEF - 1));
        issue(OP_MARK_FREE, FRAME_W'(MAX_FRAMES_DEF - 2));
        issue(OP_MARK_FREE, FRAME_W'(MAX_FRAMES_DEF - 1));
        issue(OP_FIND, '0);
        random_items(8, 1'b1);
        drain();

        write_frame_count(CFG_W'(700));
        random_items(45, 1'b0);
        drain();
        write_frame_count(CFG_W'(33));
        random_items(20, 1'b0);
        drain();

        repeat (20) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.expected_rsp.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
